FILE: design/gilbert_index_to_xy_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Gilbert index to coordinate block
// Clocked on clk, switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef GILBERT_INDEX_TO_XY_ASSERT_SVH
`define GILBERT_INDEX_TO_XY_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GIX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GIX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/gix_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gix_pkg
// Widths, types, codes and small helpers for the Gilbert index mapper.
// ----------------------------------------------------------------------------
package gix_pkg;

  localparam int COORD_BITS    = 16;
  localparam int INDEX_BITS    = 32;
  localparam int DEPTH_BITS    = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = (COORD_BITS > DEPTH_BITS) ? COORD_BITS : DEPTH_BITS;
  localparam int VEC_BITS      = COORD_BITS + 2;
  localparam int PROD_BITS     = 2 * COORD_BITS;
  localparam int WIDE_BITS     = ((PROD_BITS > INDEX_BITS) ? PROD_BITS : INDEX_BITS) + 1;
  localparam int LEVEL_BITS    = DEPTH_BITS + 1;

  typedef logic        [COORD_BITS-1:0] coord_t;
  typedef logic        [INDEX_BITS-1:0] index_t;
  typedef logic signed [VEC_BITS-1:0]   vec_t;
  typedef logic        [PROD_BITS-1:0]  prod_t;
  typedef logic        [WIDE_BITS-1:0]  wide_t;
  typedef logic        [DEPTH_BITS-1:0] depth_t;
  typedef logic        [LEVEL_BITS-1:0] level_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_DEPTH = 2'd2
  } status_t;

  localparam logic [CFG_IDX_BITS-1:0] REG_AREA_WIDTH  = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_AREA_HEIGHT = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_DEPTH_LIMIT = CFG_IDX_BITS'(2);

  localparam coord_t RESET_SIDE  = COORD_BITS'(256);
  localparam depth_t RESET_DEPTH = DEPTH_BITS'(255);

  // Magnitude of an axis vector component, cut to a side length.
  function automatic coord_t vec_mag(input vec_t v);
    vec_t a;
    a = v[VEC_BITS-1] ? -v : v;
    return a[COORD_BITS-1:0];
  endfunction

  // Unit step along a vector: -1, 0 or +1.
  function automatic vec_t vec_sign(input vec_t v);
    vec_t s;
    if (v[VEC_BITS-1]) begin
      s = '1;
    end else if (v != '0) begin
      s = VEC_BITS'(1);
    end else begin
      s = '0;
    end
    return s;
  endfunction

  // Move a magnitude along the direction of a unit step.
  function automatic vec_t step_by(input vec_t s, input vec_t m);
    vec_t r;
    if (s[VEC_BITS-1]) begin
      r = -m;
    end else if (s != '0) begin
      r = m;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  function automatic vec_t to_vec(input coord_t c);
    return $signed({{(VEC_BITS-COORD_BITS){1'b0}}, c});
  endfunction

endpackage

FILE: design/gix_index_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gix_index_if
// Valid/ready channel carrying one curve index.
// ----------------------------------------------------------------------------
interface gix_index_if;
  import gix_pkg::*;

  logic   valid;
  logic   ready;
  index_t curve_index;

  modport source (output valid, output curve_index, input ready);
  modport sink   (input valid, input curve_index, output ready);
endinterface

FILE: design/gix_coord_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gix_coord_if
// Valid/ready channel carrying one cell coordinate and its status.
// ----------------------------------------------------------------------------
interface gix_coord_if;
  import gix_pkg::*;

  logic    valid;
  logic    ready;
  coord_t  coord_x;
  coord_t  coord_y;
  status_t status;

  modport source (output valid, output coord_x, output coord_y, output status, input ready);
  modport sink   (input valid, input coord_x, input coord_y, input status, output ready);
endinterface

FILE: design/gilbert_index_to_xy.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gilbert_index_to_xy
// Curve index to (x, y) along the generalised Hilbert (Gilbert) curve.
// ----------------------------------------------------------------------------
//
//  Channel  | Direction | Payload                          | Transfer when
//  ---------+-----------+----------------------------------+-----------------
//  req      | in        | curve_index                      | valid && ready
//  rsp      | out       | coord_x, coord_y, status         | valid && ready
//  cfg      | in        | cfg_index, cfg_data              | cfg_we
//
//  Steps: take the index; per level check the depth and multiply the area, test,
//  multiply the first part's cell count (and the second's on a three-way level)
//  and descend; the last level ends after the test; then hand over the result.
//  The single shared 16x16 multiplier, used up to three times per level,
//  sets the pace.
//  Reset (rst, synchronous) returns the sequencer to idle, empties the result
//  register and loads width 256, height 256, depth limit 255.
//  A stalled result sits in the output register; a new index is still taken.
//
module gilbert_index_to_xy (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [gix_pkg::CFG_IDX_BITS-1:0]   cfg_index,
  input  logic [gix_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  gix_index_if.sink                          req,
  gix_coord_if.source                        rsp
);
  import gix_pkg::*;

  // Sequencer states, one-hot.
  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,  // wait for an index
    S_AREA   = 7'b0000010,  // depth check, multiply w * h
    S_TEST   = 7'b0000100,  // range check, leaf cases, halve the vectors
    S_FIRST  = 7'b0001000,  // multiply the first part's cell count
    S_SECOND = 7'b0010000,  // multiply the second part's cell count
    S_MOVE   = 7'b0100000,  // pick the part, descend one level
    S_DONE   = 7'b1000000   // hand the result to the output register
  } state_t;

  state_t  state;

  // Configuration registers.
  coord_t  area_width;
  coord_t  area_height;
  depth_t  depth_limit;

  // Walk registers: index left, axis vectors, position, level.
  index_t  d;
  vec_t    ax, ay, bx, by;
  vec_t    px, py;
  vec_t    ax2, ay2, bx2, by2;
  coord_t  w, h;
  coord_t  op_a, op_b;
  prod_t   prod;
  prod_t   first;
  level_t  level;
  logic    split2;
  status_t res_st;

  // Output register.
  logic    out_valid;
  coord_t  out_x, out_y;
  status_t out_st;

  // Unit steps along the current vectors.
  vec_t    dax, day, dbx, dby;
  // Floor halves and their adjusted forms.
  vec_t    hax, hay, hbx, hby;
  vec_t    ax2a, ay2a, bx2a, by2a;
  coord_t  w2, h2, w2a, h2a;
  logic    two_way;
  logic [COORD_BITS+1:0] w_x2, h_x3;

  // Shared multiplier.
  coord_t  mul_a, mul_b;
  prod_t   mul_out;

  wide_t   d_wide, sum12;
  vec_t    d_vec;
  logic    take, load_out, in_area;

  assign take     = req.valid && req.ready;
  assign load_out = (state == S_DONE) && (!out_valid || rsp.ready);

  assign req.ready   = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.coord_x = out_x;
  assign rsp.coord_y = out_y;
  assign rsp.status  = out_st;

  always_comb begin
    dax = vec_sign(ax);
    day = vec_sign(ay);
    dbx = vec_sign(bx);
    dby = vec_sign(by);

    hax = ax >>> 1;
    hay = ay >>> 1;
    hbx = bx >>> 1;
    hby = by >>> 1;
    w2  = vec_mag(hax + hay);
    h2  = vec_mag(hbx + hby);

    // Split in two when 2w > 3h.
    w_x2    = {1'b0, w, 1'b0};
    h_x3    = {2'b00, h} + {1'b0, h, 1'b0};
    two_way = (w_x2 > h_x3);

    // Make an odd half even by one unit step when the side exceeds two.
    ax2a = hax;
    ay2a = hay;
    if (w2[0] && (w > COORD_BITS'(2))) begin
      ax2a = hax + dax;
      ay2a = hay + day;
    end
    bx2a = hbx;
    by2a = hby;
    if (h2[0] && (h > COORD_BITS'(2))) begin
      bx2a = hbx + dbx;
      by2a = hby + dby;
    end
    w2a = vec_mag(ax2a + ay2a);
    h2a = vec_mag(bx2a + by2a);

    case (state)
      S_AREA: begin
        mul_a = vec_mag(ax + ay);
        mul_b = vec_mag(bx + by);
      end
      S_FIRST: begin
        mul_a = op_a;
        mul_b = op_b;
      end
      default: begin
        mul_a = w;
        mul_b = vec_mag((bx - bx2) + (by - by2));
      end
    endcase
    mul_out = prod_t'(mul_a) * prod_t'(mul_b);

    d_wide = wide_t'(d);
    sum12  = wide_t'(first) + wide_t'(prod);
    d_vec  = $signed({{(VEC_BITS-COORD_BITS){1'b0}}, d[COORD_BITS-1:0]});

    // Final cell must lie inside the rectangle.
    in_area = !px[VEC_BITS-1] && !py[VEC_BITS-1]
              && ($unsigned(px) < {{(VEC_BITS-COORD_BITS){1'b0}}, area_width})
              && ($unsigned(py) < {{(VEC_BITS-COORD_BITS){1'b0}}, area_height});
  end

  // Configuration writes; unknown indexes drop.
  always_ff @(posedge clk) begin
    if (rst) begin
      area_width  <= RESET_SIDE;
      area_height <= RESET_SIDE;
      depth_limit <= RESET_DEPTH;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_AREA_WIDTH:  area_width  <= cfg_data[COORD_BITS-1:0];
        REG_AREA_HEIGHT: area_height <= cfg_data[COORD_BITS-1:0];
        REG_DEPTH_LIMIT: depth_limit <= cfg_data[DEPTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Output register: load from the sequencer, drop on a transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      if ((res_st == ST_OK) && in_area) begin
        out_x  <= px[COORD_BITS-1:0];
        out_y  <= py[COORD_BITS-1:0];
        out_st <= ST_OK;
      end else begin
        out_x  <= '0;
        out_y  <= '0;
        out_st <= (res_st == ST_OK) ? ST_RANGE : res_st;
      end
    end
  end

  // Sequencer and walk datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (take) begin
            d     <= req.curve_index;
            px    <= '0;
            py    <= '0;
            level <= '0;
            // Major axis along the longer side; x wins a tie.
            if (area_width >= area_height) begin
              ax <= to_vec(area_width);
              ay <= '0;
              bx <= '0;
              by <= to_vec(area_height);
            end else begin
              ax <= '0;
              ay <= to_vec(area_height);
              bx <= to_vec(area_width);
              by <= '0;
            end
            state <= S_AREA;
          end
        end

        S_AREA: begin
          if (level > {1'b0, depth_limit}) begin
            res_st <= ST_DEPTH;
            state  <= S_DONE;
          end else begin
            w     <= vec_mag(ax + ay);
            h     <= vec_mag(bx + by);
            prod  <= mul_out;
            state <= S_TEST;
          end
        end

        S_TEST: begin
          if ((w == '0) || (h == '0) || (d_wide >= wide_t'(prod))) begin
            res_st <= ST_RANGE;
            state  <= S_DONE;
          end else if (h == COORD_BITS'(1)) begin
            // One cell high: straight run along a.
            px     <= px + step_by(dax, d_vec);
            py     <= py + step_by(day, d_vec);
            res_st <= ST_OK;
            state  <= S_DONE;
          end else if (w == COORD_BITS'(1)) begin
            // One cell wide: straight run along b.
            px     <= px + step_by(dbx, d_vec);
            py     <= py + step_by(dby, d_vec);
            res_st <= ST_OK;
            state  <= S_DONE;
          end else if ((w2 == '0) || (h2 == '0)) begin
            res_st <= ST_RANGE;
            state  <= S_DONE;
          end else begin
            split2 <= two_way;
            if (two_way) begin
              ax2  <= ax2a;
              ay2  <= ay2a;
              bx2  <= hbx;
              by2  <= hby;
              op_a <= w2a;
              op_b <= h;
            end else begin
              ax2  <= hax;
              ay2  <= hay;
              bx2  <= bx2a;
              by2  <= by2a;
              op_a <= h2a;
              op_b <= w2;
            end
            state <= S_FIRST;
          end
        end

        S_FIRST: begin
          first <= mul_out;
          state <= split2 ? S_MOVE : S_SECOND;
        end

        S_SECOND: begin
          prod  <= mul_out;
          state <= S_MOVE;
        end

        S_MOVE: begin
          level <= level + LEVEL_BITS'(1);
          if (split2) begin
            if (first == '0) begin
              res_st <= ST_RANGE;
              state  <= S_DONE;
            end else begin
              state <= S_AREA;
              if (d_wide < wide_t'(first)) begin
                ax <= ax2;
                ay <= ay2;
              end else begin
                px <= px + ax2;
                py <= py + ay2;
                ax <= ax - ax2;
                ay <= ay - ay2;
                d  <= INDEX_BITS'(d_wide - wide_t'(first));
              end
            end
          end else begin
            if ((first == '0) || (prod == '0)) begin
              res_st <= ST_RANGE;
              state  <= S_DONE;
            end else begin
              state <= S_AREA;
              if (d_wide < wide_t'(first)) begin
                ax <= bx2;
                ay <= by2;
                bx <= ax2;
                by <= ay2;
              end else if (d_wide < sum12) begin
                px <= px + bx2;
                py <= py + by2;
                bx <= bx - bx2;
                by <= by - by2;
                d  <= INDEX_BITS'(d_wide - wide_t'(first));
              end else begin
                // Third part runs back along the far side.
                px <= px + (ax - dax) + (bx2 - dbx);
                py <= py + (ay - day) + (by2 - dby);
                ax <= -bx2;
                ay <= -by2;
                bx <= ax2 - ax;
                by <= ay2 - ay;
                d  <= INDEX_BITS'(d_wide - sum12);
              end
            end
          end
        end

        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/gix_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gix_checker
// Port-level checks on the Gilbert index mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "gilbert_index_to_xy_assert.svh"

module gix_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input gix_pkg::coord_t  coord_x,
  input gix_pkg::coord_t  coord_y,
  input logic [1:0]       status
);
  import gix_pkg::*;

  `GIX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(coord_x) && $stable(coord_y) && $stable(status), "result changed while stalled")
  `GIX_ASSERT_NOW(a_fail_zero, out_valid && (status != ST_OK), (coord_x == '0) && (coord_y == '0), "failed result carries a coordinate")
  `GIX_ASSERT_NOW(a_status_code, out_valid, (status == ST_OK) || (status == ST_RANGE) || (status == ST_DEPTH), "undefined status code")
  `GIX_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready, "index taken while a walk is under way")

endmodule

bind gilbert_index_to_xy gix_checker u_gix_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (req.valid),
  .in_ready  (req.ready),
  .out_valid (rsp.valid),
  .out_ready (rsp.ready),
  .coord_x   (rsp.coord_x),
  .coord_y   (rsp.coord_y),
  .status    (rsp.status)
);

FILE: tb/gix_cell_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gix_cell_checker
// Watches the index and coordinate channels and the register write port of
// the Gilbert mapper. Predicts the cell for every index transfer and compares
// each coordinate transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module gix_cell_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [gix_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [gix_pkg::CFG_DATA_BITS-1:0] cfg_data,
  gix_index_if                              req,
  gix_coord_if                              rsp,
  output int                                fail_count,
  output int                                pending
);
  import gix_pkg::*;

  typedef longint unsigned span_t;

  typedef struct packed {
    coord_t  coord_x;
    coord_t  coord_y;
    status_t status;
  } cell_t;

  coord_t area_w = RESET_SIDE;
  coord_t area_h = RESET_SIDE;
  depth_t depth_lim = RESET_DEPTH;
  cell_t  expected_cells[$];

  function automatic span_t mag_of(input longint v);
    span_t r;
    r = (v < 0) ? -v : v;
    return r;
  endfunction

  function automatic longint sgn_of(input longint v);
    return (v > 0) ? 64'sd1 : ((v < 0) ? -64'sd1 : 64'sd0);
  endfunction

  // Walk down the Gilbert subdivision until the index lands in a unit-thin
  // strip, or a check trips.
  function automatic cell_t gilbert_cell(input coord_t wd, input coord_t ht,
                                         input depth_t lim, input index_t idx);
    cell_t   res;
    status_t st;
    longint  x, y, ax, ay, bx, by, ax2, ay2, bx2, by2;
    longint  dax, day, dbx, dby, nax, nay, nbx, nby;
    span_t   d, w, h, w2, h2, first, second;
    int unsigned lvl;
    bit      done;

    res = '0;
    res.status = ST_RANGE;
    d = idx;
    if (wd == 0 || ht == 0 || d >= span_t'(wd) * span_t'(ht)) begin
      return res;
    end

    x = 0;
    y = 0;
    lvl = 0;
    done = 1'b0;
    st = ST_OK;
    if (wd >= ht) begin
      ax = wd; ay = 0; bx = 0; by = ht;
    end else begin
      ax = 0; ay = ht; bx = wd; by = 0;
    end

    while (!done) begin
      if (lvl > lim) begin
        st = ST_DEPTH;
        done = 1'b1;
      end else begin
        w = mag_of(ax + ay);
        h = mag_of(bx + by);
        if (w == 0 || h == 0 || d >= w * h) begin
          st = ST_RANGE;
          done = 1'b1;
        end else begin
          dax = sgn_of(ax); day = sgn_of(ay);
          dbx = sgn_of(bx); dby = sgn_of(by);
          if (h == 1) begin
            x += dax * longint'(d);
            y += day * longint'(d);
            done = 1'b1;
          end else if (w == 1) begin
            x += dbx * longint'(d);
            y += dby * longint'(d);
            done = 1'b1;
          end else begin
            ax2 = ax >>> 1; ay2 = ay >>> 1;
            bx2 = bx >>> 1; by2 = by >>> 1;
            w2 = mag_of(ax2 + ay2);
            h2 = mag_of(bx2 + by2);
            if (w2 == 0 || h2 == 0) begin
              st = ST_RANGE;
              done = 1'b1;
            end else if (2 * w > 3 * h) begin
              // long and flat: two parts along the major axis
              if (w2[0] && w > 2) begin
                ax2 += dax; ay2 += day;
              end
              first = mag_of(ax2 + ay2) * mag_of(bx + by);
              if (first == 0) begin
                st = ST_RANGE;
                done = 1'b1;
              end else if (d < first) begin
                ax = ax2; ay = ay2;
              end else begin
                x += ax2; y += ay2;
                ax -= ax2; ay -= ay2;
                d -= first;
              end
            end else begin
              // three parts: up, across, back down
              if (h2[0] && h > 2) begin
                bx2 += dbx; by2 += dby;
              end
              first = mag_of(bx2 + by2) * mag_of(ax2 + ay2);
              second = mag_of(ax + ay) * mag_of((bx - bx2) + (by - by2));
              if (first == 0 || second == 0) begin
                st = ST_RANGE;
                done = 1'b1;
              end else if (d < first) begin
                ax = bx2; ay = by2;
                bx = ax2; by = ay2;
              end else if (d < first + second) begin
                x += bx2; y += by2;
                bx -= bx2; by -= by2;
                d -= first;
              end else begin
                nax = -bx2; nay = -by2;
                nbx = -(ax - ax2); nby = -(ay - ay2);
                x += (ax - dax) + (bx2 - dbx);
                y += (ay - day) + (by2 - dby);
                ax = nax; ay = nay; bx = nbx; by = nby;
                d -= first + second;
              end
            end
          end
        end
      end
      if (!done) begin
        lvl++;
      end
    end

    if (st == ST_OK && (x < 0 || y < 0 || x >= longint'(wd) || y >= longint'(ht))) begin
      st = ST_RANGE;
    end
    if (st == ST_OK) begin
      res.coord_x = x[COORD_BITS-1:0];
      res.coord_y = y[COORD_BITS-1:0];
    end
    res.status = st;
    return res;
  endfunction

  always @(posedge clk) begin
    cell_t want;
    if (rst) begin
      area_w = RESET_SIDE;
      area_h = RESET_SIDE;
      depth_lim = RESET_DEPTH;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_AREA_WIDTH:  area_w = cfg_data[COORD_BITS-1:0];
          REG_AREA_HEIGHT: area_h = cfg_data[COORD_BITS-1:0];
          REG_DEPTH_LIMIT: depth_lim = cfg_data[DEPTH_BITS-1:0];
          default: ;
        endcase
      end

      if (rsp.valid && rsp.ready) begin
        if (expected_cells.size() == 0) begin
          $error("unexpected result: x %0d y %0d status %0d",
                 rsp.coord_x, rsp.coord_y, rsp.status);
          fail_count++;
        end else begin
          want = expected_cells.pop_front();
          if (rsp.coord_x !== want.coord_x) begin
            $error("coord_x mismatch: expected %0d, actual %0d", want.coord_x, rsp.coord_x);
            fail_count++;
          end
          if (rsp.coord_y !== want.coord_y) begin
            $error("coord_y mismatch: expected %0d, actual %0d", want.coord_y, rsp.coord_y);
            fail_count++;
          end
          if (rsp.status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, rsp.status);
            fail_count++;
          end
        end
      end

      if (req.valid && req.ready) begin
        expected_cells.push_back(gilbert_cell(area_w, area_h, depth_lim, req.curve_index));
      end
    end
    pending = expected_cells.size();
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the Gilbert index to coordinate mapper.
// Walks the block through a set of area shapes and depth limits, first with
// hand-picked indices at the corners, then with random areas and indices,
// while the index sender pauses in bursts and the result receiver stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import gix_pkg::*;

  typedef longint unsigned span_t;

  // Stall behaviour of the result receiver, picked afresh every so often.
  typedef enum int {
    RX_FREE,      // always ready
    RX_RANDOM,    // coin toss every cycle
    RX_THROTTLE   // ready when rx_tick is a multiple of six
  } rx_mode_t;

  // Index 3 decodes to no register; writes there must leave all state alone.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = CFG_IDX_BITS'(3);

  // Slowest transfer gap: a 65535 by 65535 area takes the longest walk per
  // index, plus receiver and sender stalls; take that several times over.
  localparam int IDLE_LIMIT   = 4000;
  localparam int SETTLE_TICKS = 300;
  localparam int RAND_PHASES  = 18;
  localparam int PHASE_ITEMS  = 40;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;

  int       failures;
  int       outstanding;
  int       burst_left = 0;
  int       idle_cycles = 0;
  coord_t   cur_w;
  coord_t   cur_h;
  rx_mode_t rx_mode = RX_FREE;
  int       rx_left = 0;
  int       rx_tick = 0;

  gix_index_if req_if ();
  gix_coord_if rsp_if ();

  gilbert_index_to_xy u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_if),
    .rsp       (rsp_if)
  );

  gix_cell_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req        (req_if),
    .rsp        (rsp_if),
    .fail_count (failures),
    .pending    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver: hold each stall mode for a random stretch, free-running
  // stretches included, so stalls land on every phase of the computation.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 2));
      rx_left <= $urandom_range(16, 96);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_FREE:   rsp_if.ready <= 1'b1;
      RX_RANDOM: rsp_if.ready <= 1'($urandom_range(0, 1));
      default:   rsp_if.ready <= (rx_tick % 6 == 0);
    endcase
  end

  // Watchdog: count cycles in which neither channel makes a transfer.
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Present one index and hold it until the transfer. Bursts of random
  // length are separated by random gaps; valid stays high within a burst.
  task automatic send_index(input index_t idx);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        req_if.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    req_if.valid = 1'b1;
    req_if.curve_index = idx;
    do @(posedge clk); while (!req_if.ready);
    @(negedge clk);
  endtask

  // Drop valid and wait until every predicted result has been transferred.
  task automatic drain();
    req_if.valid = 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Registers change only with the block idle, so drain first.
  task automatic configure(input coord_t w, input coord_t h,
                           input logic [CFG_DATA_BITS-1:0] lim_word);
    drain();
    write_reg(REG_AREA_WIDTH, CFG_DATA_BITS'(w));
    write_reg(REG_AREA_HEIGHT, CFG_DATA_BITS'(h));
    write_reg(REG_DEPTH_LIMIT, lim_word);
    cur_w = w;
    cur_h = h;
  endtask

  // Mostly small sides to keep the run short; now and then a zero or a
  // side up to the full range.
  function automatic coord_t pick_side();
    case ($urandom_range(0, 9))
      0:       return coord_t'($urandom_range(0, 2));
      1:       return coord_t'($urandom_range(1, 65535));
      2:       return coord_t'(65535);
      default: return coord_t'($urandom_range(3, 40));
    endcase
  endfunction

  // Mostly the plain limit; sometimes a shallow or a random one, both with junk
  // in the upper byte that the register must drop.
  function automatic logic [CFG_DATA_BITS-1:0] pick_depth_word();
    case ($urandom_range(0, 5))
      0:       return {8'($urandom), 8'($urandom_range(0, 6))};
      1:       return CFG_DATA_BITS'($urandom);
      default: return CFG_DATA_BITS'(RESET_DEPTH);
    endcase
  endfunction

  // Mostly legal indices; the rest sit on the area boundary or anywhere.
  function automatic index_t pick_index();
    span_t area;
    area = span_t'(cur_w) * span_t'(cur_h);
    if (area == 0) begin
      return $urandom;
    end
    case ($urandom_range(0, 9))
      0:       return $urandom;
      1:       return index_t'(area);
      2:       return index_t'(area - 1);
      3:       return index_t'($urandom_range(0, 15));
      default: return index_t'({$urandom, $urandom} % area);
    endcase
  endfunction

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_AREA_WIDTH;
    cfg_data = '0;
    req_if.valid = 1'b0;
    req_if.curve_index = '0;
    cur_w = RESET_SIDE;
    cur_h = RESET_SIDE;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Reset values: 256 by 256, full depth. Corners, the last legal index,
    // the first illegal one and the top of the index range.
    send_index(index_t'(0));
    send_index(index_t'(1));
    send_index(index_t'(65535));
    send_index(index_t'(65536));
    send_index(32'hFFFF_FFFF);
    send_index(32'h8000_0000);

    // Zero width, then zero height: every index fails.
    configure(coord_t'(0), coord_t'(9), CFG_DATA_BITS'(RESET_DEPTH));
    send_index(index_t'(0));
    send_index(index_t'(3));
    configure(coord_t'(9), coord_t'(0), CFG_DATA_BITS'(RESET_DEPTH));
    send_index(index_t'(0));

    // Largest area: extreme coordinates and the exact area bound.
    configure(coord_t'(65535), coord_t'(65535), CFG_DATA_BITS'(RESET_DEPTH));
    send_index(index_t'(0));
    send_index(32'hFFFE_0000);
    send_index(32'hFFFE_0001);
    send_index(32'h7FFF_1234);

    // Depth limit zero, written with junk above the register width; any
    // descent past the root fails. The spare index must change nothing.
    configure(RESET_SIDE, RESET_SIDE, 16'hA500);
    write_reg(REG_SPARE, 16'hFFFF);
    send_index(index_t'(5));
    send_index(index_t'(0));

    // A single cell ends at the root even with depth limit zero.
    configure(coord_t'(1), coord_t'(1), 16'hFF00);
    send_index(index_t'(0));
    send_index(index_t'(1));

    // One cell wide and tall: a straight run along y.
    configure(coord_t'(1), coord_t'(65535), CFG_DATA_BITS'(RESET_DEPTH));
    send_index(index_t'(0));
    send_index(index_t'(65534));
    send_index(index_t'(65535));

    // Wide and flat: two-way splits.
    configure(coord_t'(20), coord_t'(3), CFG_DATA_BITS'(RESET_DEPTH));
    send_index(index_t'(0));
    send_index(index_t'(59));

    // Odd sides: halves stepped to even, three-way splits.
    configure(coord_t'(7), coord_t'(5), CFG_DATA_BITS'(RESET_DEPTH));
    send_index(index_t'(17));
    send_index(index_t'(34));

    // Random areas and limits, each with a run of random indices.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      configure(pick_side(), pick_side(), pick_depth_word());
      if ($urandom_range(0, 3) == 0) begin
        write_reg(REG_SPARE, CFG_DATA_BITS'($urandom));
      end
      repeat (PHASE_ITEMS) send_index(pick_index());
    end

    // Let the tail drain, then allow a latency's worth for stray results.
    drain();
    repeat (SETTLE_TICKS) @(negedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
